FILE: src/thread_table_round_robin_scheduler_top_assert.svh
// Assertion macros for the thread scheduler checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef THREAD_TABLE_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define THREAD_TABLE_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TTRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication.
`define TTRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

FILE: src/ttrr_pkg.sv
// Types and constants of the round-robin thread scheduler.
// No dependencies.
package ttrr_pkg;

  localparam int SLOTS    = 32;
  localparam int MUTEXES  = 4;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int MTX_W    = 2;
  localparam int FIFO_AW  = $clog2(MUTEXES) + SLOT_W;
  localparam logic [5:0] NO_SLOT = 6'h3f;

  typedef enum logic [2:0] {
    FN_SCHED   = 3'd0,
    FN_CREATE  = 3'd1,
    FN_EXIT    = 3'd2,
    FN_JOIN    = 3'd3,
    FN_LOCK    = 3'd4,
    FN_TRYLOCK = 3'd5,
    FN_UNLOCK  = 3'd6,
    FN_INIT    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NO_THREAD = 3'd3,
    ST_BUSY      = 3'd4,
    ST_NOT_OWNER = 3'd5
  } status_e;

  typedef enum logic {
    PH_IDLE,
    PH_EXEC
  } phase_e;

  typedef struct packed {
    func_e       func;
    logic [5:0]  target_id;
    logic [1:0]  mutex_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  thread_id;
    logic        switched;
    logic [4:0]  prev_id;
  } res_t;

endpackage

FILE: src/thread_table_round_robin_scheduler_top.sv
// The accepting edge registers the request and the memory reads; busy is high
// for the one cycle in which the read-modify-write runs, then valid_o strobes
// with the registered result. No new item is taken while busy. The memory read
// of the join waiter and of the waiter FIFO head is why the reads come first. The receiver cannot stall.
// Reset (async, rst_ni low): slot 0 running, others free, all mutexes free,
// all join waiters none, FIFOs empty. No clearing pass.
module thread_table_round_robin_scheduler_top
  import ttrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output res_t result_o
);

  // Slot state held as class vectors; a runnable slot is running when it is
  // the current one and ready otherwise. Free means no class bit set.
  logic [SLOTS-1:0] run_q, run_d, blk_q, blk_d, zom_q, zom_d;
  logic [SLOT_W-1:0] cur_q, cur_d;

  // Join waiters: memory plus a valid bit per slot (invalid reads as none).
  logic [5:0]       jw_mem [SLOTS];
  logic [SLOTS-1:0] jw_vld_q, jw_vld_d;
  logic [5:0]       jw_rd_q;
  logic             jw_we;
  logic [SLOT_W-1:0] jw_waddr;
  logic [5:0]       jw_wdata;

  // Mutex waiter FIFOs: one memory, circular per mutex (head + count).
  logic [SLOT_W-1:0] fifo_mem [MUTEXES*SLOTS];
  logic [SLOT_W-1:0] fifo_rd_q;
  logic              fifo_we;
  logic [FIFO_AW-1:0] fifo_waddr;

  logic [MUTEXES-1:0] lck_q, lck_d;
  logic [5:0]         own_q [MUTEXES];
  logic [5:0]         own_d [MUTEXES];
  logic [SLOT_W-1:0]  head_q [MUTEXES];
  logic [SLOT_W-1:0]  head_d [MUTEXES];
  logic [CNT_W-1:0]   cnt_q [MUTEXES];
  logic [CNT_W-1:0]   cnt_d [MUTEXES];

  phase_e ph_q, ph_d;
  req_t   req_q;
  res_t   res_q, res_d;
  logic   valid_q;
  logic   accept;

  assign accept   = start && !busy;
  assign busy     = (ph_q == PH_EXEC);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  // Sequencer: IDLE takes an item and issues reads, EXEC updates state.
  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PH_IDLE: if (accept) ph_d = PH_EXEC;
      PH_EXEC: ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      valid_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      valid_q <= (ph_q == PH_EXEC);
    end
  end

  // Read stage: request capture and memory reads at the accepting edge.
  // Writes only land in EXEC; in IDLE the execute logic sees a stale request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i;
      jw_rd_q   <= jw_mem[cur_q];
      fifo_rd_q <= fifo_mem[{req_i.mutex_id[$clog2(MUTEXES)-1:0],
                             head_q[req_i.mutex_id[$clog2(MUTEXES)-1:0]]}];
    end
    if (jw_we && ph_q == PH_EXEC) jw_mem[jw_waddr] <= jw_wdata;
    if (fifo_we && ph_q == PH_EXEC) fifo_mem[fifo_waddr] <= cur_q;
    if (ph_q == PH_EXEC) res_q <= res_d;
  end

  // Execute stage.
  always_comb begin
    logic [$clog2(MUTEXES)-1:0] m;
    logic [5:0]  jw;
    logic [5:0]  tgt;
    logic        do_sched;
    logic        created;
    logic        found;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] pick;
    logic [SLOT_W:0]   sum;
    logic [SLOTS-1:0]  free_v;
    status_e     st;

    m        = req_q.mutex_id[$clog2(MUTEXES)-1:0];
    tgt      = req_q.target_id;
    jw       = jw_vld_q[cur_q] ? jw_rd_q : NO_SLOT;
    run_d    = run_q;
    blk_d    = blk_q;
    zom_d    = zom_q;
    jw_vld_d = jw_vld_q;
    lck_d    = lck_q;
    own_d    = own_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    jw_we    = 1'b0;
    jw_waddr = cur_q;
    jw_wdata = NO_SLOT;
    fifo_we  = 1'b0;
    sum      = {1'b0, head_q[m]} + cnt_q[m][SLOT_W:0];
    fifo_waddr = {m, (sum >= (SLOT_W+1)'(SLOTS)) ? sum[SLOT_W-1:0] - SLOT_W'(SLOTS)
                                                 : sum[SLOT_W-1:0]};
    do_sched = 1'b0;
    created  = 1'b0;
    new_slot = '0;
    found    = 1'b0;
    pick     = cur_q;
    st       = ST_OK;
    free_v   = ~(run_q | blk_q | zom_q);

    if (int'(req_q.func) >= int'(FN_LOCK) && int'(req_q.mutex_id) >= MUTEXES) begin
      st = ST_BUSY;
    end else begin
      case (req_q.func)
        FN_SCHED: do_sched = 1'b1;
        FN_CREATE: begin
          st = ST_NO_SLOT;
          for (int i = SLOTS-1; i >= 1; i--) begin
            if (free_v[i]) begin
              new_slot = SLOT_W'(i);
              created  = 1'b1;
            end
          end
          if (created) begin
            st               = ST_OK;
            run_d[new_slot]  = 1'b1;
            jw_vld_d[new_slot] = 1'b1;
            jw_we            = 1'b1;
            jw_waddr         = new_slot;
            jw_wdata         = NO_SLOT;
          end
        end
        FN_EXIT: begin
          run_d[cur_q] = 1'b0;
          blk_d[cur_q] = 1'b0;
          zom_d[cur_q] = 1'b1;
          if (int'(jw) < SLOTS && blk_d[jw[SLOT_W-1:0]]) begin
            blk_d[jw[SLOT_W-1:0]] = 1'b0;
            run_d[jw[SLOT_W-1:0]] = 1'b1;
          end
          do_sched = 1'b1;
        end
        FN_JOIN: begin
          if (int'(tgt) >= SLOTS || free_v[tgt[SLOT_W-1:0]]) begin
            st = ST_NO_THREAD;
          end else begin
            jw_we    = 1'b1;
            jw_waddr = tgt[SLOT_W-1:0];
            jw_wdata = 6'(cur_q);
            jw_vld_d[tgt[SLOT_W-1:0]] = 1'b1;
            if (zom_q[tgt[SLOT_W-1:0]]) begin
              zom_d[tgt[SLOT_W-1:0]] = 1'b0;
            end else begin
              run_d[cur_q] = 1'b0;
              zom_d[cur_q] = 1'b0;
              blk_d[cur_q] = 1'b1;
              st           = ST_BLOCKED;
              do_sched     = 1'b1;
            end
          end
        end
        FN_LOCK: begin
          if (!lck_q[m]) begin
            lck_d[m] = 1'b1;
            own_d[m] = 6'(cur_q);
          end else begin
            if (int'(cnt_q[m]) < SLOTS) begin
              fifo_we  = 1'b1;
              cnt_d[m] = cnt_q[m] + 1'b1;
            end
            run_d[cur_q] = 1'b0;
            zom_d[cur_q] = 1'b0;
            blk_d[cur_q] = 1'b1;
            st           = ST_BLOCKED;
            do_sched     = 1'b1;
          end
        end
        FN_TRYLOCK: begin
          if (lck_q[m]) begin
            st = ST_BUSY;
          end else begin
            lck_d[m] = 1'b1;
            own_d[m] = 6'(cur_q);
          end
        end
        FN_UNLOCK: begin
          if (!lck_q[m] || own_q[m] != 6'(cur_q)) begin
            st = ST_NOT_OWNER;
          end else begin
            lck_d[m] = 1'b0;
            own_d[m] = NO_SLOT;
            if (cnt_q[m] != '0) begin
              cnt_d[m]  = cnt_q[m] - 1'b1;
              head_d[m] = (int'(head_q[m]) == SLOTS-1) ? '0 : head_q[m] + 1'b1;
              if (blk_q[fifo_rd_q]) begin
                blk_d[fifo_rd_q] = 1'b0;
                run_d[fifo_rd_q] = 1'b1;
              end
            end
          end
        end
        default: begin // mutex init
          lck_d[m] = 1'b0;
          own_d[m] = NO_SLOT;
          cnt_d[m] = '0;
        end
      endcase
    end

    // Round-robin pick from the slot after the current one; the nearest wins.
    for (int k = SLOTS; k >= 1; k--) begin
      logic [SLOT_W:0] ix;
      ix = {1'b0, cur_q} + (SLOT_W+1)'(k);
      if (ix >= (SLOT_W+1)'(SLOTS)) ix = ix - (SLOT_W+1)'(SLOTS);
      if (run_d[ix[SLOT_W-1:0]]) begin
        pick  = ix[SLOT_W-1:0];
        found = 1'b1;
      end
    end
    cur_d = (do_sched && found) ? pick : cur_q;

    res_d.status    = st;
    res_d.thread_id = 5'(created ? new_slot : cur_d);
    res_d.switched  = (cur_d != cur_q);
    res_d.prev_id   = 5'(cur_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= SLOTS'(1);
      blk_q    <= '0;
      zom_q    <= '0;
      cur_q    <= '0;
      jw_vld_q <= '0;
      lck_q    <= '0;
      for (int i = 0; i < MUTEXES; i++) begin
        own_q[i]  <= NO_SLOT;
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (ph_q == PH_EXEC) begin
      run_q    <= run_d;
      blk_q    <= blk_d;
      zom_q    <= zom_d;
      cur_q    <= cur_d;
      jw_vld_q <= jw_vld_d;
      lck_q    <= lck_d;
      own_q    <= own_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: src/ttrr_checker.sv
// Port-level checker for the thread scheduler, bound to the top level.
// Depends on ttrr_pkg and the assertion macro header.
`include "thread_table_round_robin_scheduler_top_assert.svh"
module ttrr_checker
  import ttrr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input res_t result_o
);

  `TTRR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `TTRR_ASSERT_IMP(a_accept_result, start && !busy, ##2 valid_o)
  `TTRR_ASSERT_NXT(a_single_strobe, valid_o, !valid_o)
  `TTRR_ASSERT_IMP(a_switch_moves, valid_o && result_o.switched,
                   result_o.thread_id != result_o.prev_id)

endmodule

bind thread_table_round_robin_scheduler_top ttrr_checker u_ttrr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .valid_o  (valid_o),
  .result_o (result_o)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for thread_table_round_robin_scheduler_top: directed and random requests,
// each checked against a predictor of the thread table and the mutex bank kept here.
// Depends on ttrr_pkg and the scheduler top level.
module tb;
  import ttrr_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  // Thread slot states as the block keeps them.
  typedef enum logic [2:0] {
    TH_FREE    = 3'd0,
    TH_RUNNING = 3'd1,
    TH_READY   = 3'd2,
    TH_BLOCKED = 3'd3,
    TH_ZOMBIE  = 3'd4
  } thr_state_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  res_t result_o;

  thread_table_round_robin_scheduler_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted copy of the thread table and the mutex bank.
  thr_state_e thr_state [SLOTS];
  logic [5:0] join_wait [SLOTS];
  logic [4:0] cur_thr;
  logic       mtx_held  [MUTEXES];
  logic [5:0] mtx_owner [MUTEXES];
  logic [4:0] mtx_queue [MUTEXES][SLOTS];
  int         mtx_qlen  [MUTEXES];

  res_t outcome_q [$];
  int   mismatches = 0;

  function automatic void clear_table();
    for (int s = 0; s < SLOTS; s++) begin
      thr_state[s] = TH_FREE;
      join_wait[s] = NO_SLOT;
    end
    thr_state[0] = TH_RUNNING;
    cur_thr = '0;
    for (int m = 0; m < MUTEXES; m++) begin
      mtx_held[m]  = 1'b0;
      mtx_owner[m] = NO_SLOT;
      mtx_qlen[m]  = 0;
    end
  endfunction

  // Round-robin pick starting after the current thread.
  function automatic void rotate();
    int  idx;
    int  pick;
    bit  found;
    idx = int'(cur_thr) + 1;
    pick = 0;
    found = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (idx >= SLOTS) idx = 0;
      if (!found && (thr_state[idx] == TH_READY || thr_state[idx] == TH_RUNNING)) begin
        pick = idx;
        found = 1;
      end
      idx++;
    end
    if (found && pick != int'(cur_thr)) begin
      if (thr_state[cur_thr] == TH_RUNNING) thr_state[cur_thr] = TH_READY;
      thr_state[pick] = TH_RUNNING;
      cur_thr = pick[4:0];
    end
  endfunction

  function automatic res_t apply_request(req_t r);
    res_t       o;
    logic [4:0] prev;
    logic [5:0] jw;
    logic [4:0] w;
    int         m;
    int         n;
    bit         made;
    logic [4:0] fresh;
    prev = cur_thr;
    m = int'(r.mutex_id);
    made = 0;
    fresh = '0;
    o.status = ST_OK;
    if (r.func inside {FN_LOCK, FN_TRYLOCK, FN_UNLOCK, FN_INIT} && m >= MUTEXES) begin
      o.status = ST_BUSY;
    end else begin
      case (r.func)
        FN_SCHED: rotate();
        FN_CREATE: begin
          o.status = ST_NO_SLOT;
          for (int s = 1; s < SLOTS; s++) begin
            if (!made && thr_state[s] == TH_FREE) begin
              thr_state[s] = TH_READY;
              join_wait[s] = NO_SLOT;
              fresh = s[4:0];
              made = 1;
              o.status = ST_OK;
            end
          end
        end
        FN_EXIT: begin
          jw = join_wait[cur_thr];
          thr_state[cur_thr] = TH_ZOMBIE;
          if (int'(jw) < SLOTS && thr_state[jw] == TH_BLOCKED) thr_state[jw] = TH_READY;
          rotate();
        end
        FN_JOIN: begin
          if (int'(r.target_id) >= SLOTS || thr_state[r.target_id] == TH_FREE) begin
            o.status = ST_NO_THREAD;
          end else begin
            join_wait[r.target_id] = {1'b0, cur_thr};
            if (thr_state[r.target_id] == TH_ZOMBIE) begin
              thr_state[r.target_id] = TH_FREE;
            end else begin
              thr_state[cur_thr] = TH_BLOCKED;
              o.status = ST_BLOCKED;
              rotate();
            end
          end
        end
        FN_LOCK: begin
          if (!mtx_held[m]) begin
            mtx_held[m]  = 1'b1;
            mtx_owner[m] = {1'b0, cur_thr};
          end else begin
            // A full waiter queue drops the entry, but the thread still blocks.
            if (mtx_qlen[m] < SLOTS) begin
              mtx_queue[m][mtx_qlen[m]] = cur_thr;
              mtx_qlen[m]++;
            end
            thr_state[cur_thr] = TH_BLOCKED;
            o.status = ST_BLOCKED;
            rotate();
          end
        end
        FN_TRYLOCK: begin
          if (mtx_held[m]) begin
            o.status = ST_BUSY;
          end else begin
            mtx_held[m]  = 1'b1;
            mtx_owner[m] = {1'b0, cur_thr};
          end
        end
        FN_UNLOCK: begin
          if (!mtx_held[m] || mtx_owner[m] != {1'b0, cur_thr}) begin
            o.status = ST_NOT_OWNER;
          end else begin
            mtx_held[m]  = 1'b0;
            mtx_owner[m] = NO_SLOT;
            if (mtx_qlen[m] > 0) begin
              n = mtx_qlen[m];
              w = mtx_queue[m][0];
              for (int i = 0; i + 1 < n; i++) mtx_queue[m][i] = mtx_queue[m][i + 1];
              mtx_qlen[m] = n - 1;
              // Woken thread goes back to ready.
              if (thr_state[w] == TH_BLOCKED) thr_state[w] = TH_READY;
            end
          end
        end
        default: begin
          mtx_held[m]  = 1'b0;
          mtx_owner[m] = NO_SLOT;
          mtx_qlen[m]  = 0;
        end
      endcase
    end
    o.thread_id = made ? fresh : cur_thr;
    o.switched  = (cur_thr != prev);
    o.prev_id   = prev;
    return o;
  endfunction

  // Hold start until the block takes the item; predict at the accepting edge.
  task automatic issue(input func_e f, input logic [5:0] tgt, input logic [1:0] mid);
    req_t r;
    r.func = f;
    r.target_id = tgt;
    r.mutex_id = mid;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    outcome_q.push_back(apply_request(r));
  endtask

  // Sender gap of random length, taken with the given percentage.
  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Results come one per item; no backpressure.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && valid_o) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        exp_r = outcome_q.pop_front();
        if (result_o.status !== exp_r.status || result_o.thread_id !== exp_r.thread_id ||
            result_o.switched !== exp_r.switched || result_o.prev_id !== exp_r.prev_id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, result_o);
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a result.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[thread_table_round_robin_scheduler_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Error paths, self join, lock by the owner, join on a zombie.
  task automatic test_directed();
    issue(FN_SCHED, 6'd0, 2'd0);      // nothing else runnable: no switch
    issue(FN_JOIN, 6'd63, 2'd0);      // target out of range
    issue(FN_JOIN, 6'd5, 2'd3);       // free target
    issue(FN_UNLOCK, 6'd0, 2'd1);     // unlock of a free mutex
    issue(FN_CREATE, 6'd0, 2'd0);
    issue(FN_CREATE, 6'd0, 2'd0);
    issue(FN_LOCK, 6'd0, 2'd0);
    issue(FN_TRYLOCK, 6'd0, 2'd0);    // held: busy
    issue(FN_LOCK, 6'd0, 2'd0);       // owner blocks on its own mutex
    issue(FN_UNLOCK, 6'd0, 2'd0);     // not owner
    issue(FN_LOCK, 6'd0, 2'd0);
    issue(FN_SCHED, 6'd0, 2'd0);
    issue(FN_TRYLOCK, 6'd0, 2'd2);
    issue(FN_UNLOCK, 6'd0, 2'd2);
    issue(FN_EXIT, 6'd0, 2'd0);       // zombie left behind
    issue(FN_JOIN, 6'd2, 2'd0);       // join a zombie or a live thread
    issue(FN_JOIN, {1'b0, cur_thr}, 2'd0);   // self join
    issue(FN_INIT, 6'd0, 2'd0);       // waiters stay blocked
    issue(FN_CREATE, 6'd0, 2'd3);
    issue(FN_SCHED, 6'd0, 2'd3);
    issue(FN_LOCK, 6'd0, 2'd3);
    issue(FN_UNLOCK, 6'd0, 2'd3);
    issue(FN_EXIT, 6'd0, 2'd0);
  endtask

  // Fill the table so create runs out of slots.
  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 1; i++) begin
      issue(FN_CREATE, 6'(i), 2'(i));
      maybe_pause(30);
    end
  endtask

  // Mostly well-formed traffic: join targets mostly in range, unlocks mostly by the owner.
  task automatic test_random(input int count, input int idle_pct);
    int   roll;
    int   mid;
    logic [5:0] tgt;
    func_e f;
    for (int k = 0; k < count; k++) begin
      maybe_pause(idle_pct);
      roll = $urandom_range(0, 99);
      if (roll < 20) f = FN_SCHED;
      else if (roll < 35) f = FN_CREATE;
      else if (roll < 45) f = FN_EXIT;
      else if (roll < 57) f = FN_JOIN;
      else if (roll < 72) f = FN_LOCK;
      else if (roll < 80) f = FN_TRYLOCK;
      else if (roll < 97) f = FN_UNLOCK;
      else f = FN_INIT;
      tgt = ($urandom_range(0, 99) < 10) ? 6'($urandom_range(32, 63))
                                          : 6'($urandom_range(0, 31));
      mid = $urandom_range(0, MUTEXES - 1);
      if (f == FN_UNLOCK && $urandom_range(0, 99) < 70) begin
        for (int m = 0; m < MUTEXES; m++)
          if (mtx_held[m] && mtx_owner[m] == {1'b0, cur_thr}) mid = m;
      end
      issue(f, tgt, 2'(mid));
    end
  endtask

  initial begin
    clear_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(150, 0);
    test_random(150, 68);
    test_random(150, 0);
    test_random(150, 25);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[thread_table_round_robin_scheduler_top] OK");
    end else begin
      $display("[thread_table_round_robin_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
